/* rtl/assert_macros.svh */
// Assertion macros shared by the gate sequencer RTL.
// With SYNTH defined the macros expand to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Antecedent in this cycle implies consequent in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Antecedent in this cycle implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

/* rtl/gms_pkg.sv */
package gms_pkg;

  // Configuration port geometry.
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  // Register reset values.
  localparam logic [7:0]  RST_FULL_OPEN  = 8'd58;
  localparam logic [7:0]  RST_HALF_OPEN  = 8'd37;
  localparam logic [7:0]  RST_FAST_DELAY = 8'd50;
  localparam logic [3:0]  RST_SLOW_ZONE  = 4'd3;
  localparam logic [15:0] RST_EXP_TICKS  = 16'd680;
  localparam logic [7:0]  RST_DUTY_MAX   = 8'd120;
  localparam logic [7:0]  RST_DUTY_MIN   = 8'd105;
  localparam logic [7:0]  RST_SLOW_DUTY  = 8'd34;

  // Fast duty mapping.
  localparam logic [7:0]  DUTY_RESET = 8'd120;
  localparam logic [15:0] SLOW_LIMIT = 16'd425;
  localparam logic [15:0] DUTY_SCALE = 16'd10000;
  localparam logic [15:0] DUTY_SPAN  = 16'd50000;
  localparam logic [15:0] IC_MAX     = 16'hFFFF;
  localparam logic [7:0]  POS_MAX    = 8'hFF;

  // Division by the span is done as 50000 = 16 * 3125: a shift by four, then a
  // multiply by the rounded-up reciprocal of 3125 scaled by 2^32, which is exact
  // for every dividend below 2^20.
  localparam int          SPAN_SHIFT  = 4;
  localparam int          RECIP_SHIFT = 32;
  localparam logic [20:0] RECIP_SPAN  = 21'd1374390;

  // Shared divider and multiplier geometry.
  localparam int DIV_NUM_W = 24;
  localparam int DIV_DEN_W = 16;
  localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);
  localparam int MUL_W     = 21;

  typedef enum logic [2:0] {
    REG_FULL_OPEN  = 3'd0,
    REG_HALF_OPEN  = 3'd1,
    REG_FAST_DELAY = 3'd2,
    REG_SLOW_ZONE  = 3'd3,
    REG_EXP_TICKS  = 3'd4,
    REG_DUTY_MAX   = 3'd5,
    REG_DUTY_MIN   = 3'd6,
    REG_SLOW_DUTY  = 3'd7
  } reg_idx_t;

  typedef enum logic [2:0] {
    MODE_HOMING    = 3'd0,
    MODE_IDLE      = 3'd1,
    MODE_OPEN_HALF = 3'd2,
    MODE_OPEN_FULL = 3'd3,
    MODE_CLOSING   = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    BR_BRAKE = 2'd0,
    BR_OPEN  = 2'd1,
    BR_CLOSE = 2'd2
  } bridge_t;

  typedef struct packed {
    logic [7:0]  full_open_steps;
    logic [7:0]  half_open_steps;
    logic [7:0]  fast_delay_tenths;
    logic [3:0]  slow_zone_steps;
    logic [15:0] expected_step_ticks;
    logic [7:0]  fast_duty_max;
    logic [7:0]  fast_duty_min;
    logic [7:0]  slow_duty;
  } cfg_t;

  typedef struct packed {
    logic step_pulse;
    logic tenth_tick;
    logic half_button;
    logic full_button;
    logic confirm_button;
    logic fault;
  } item_t;

  typedef struct packed {
    bridge_t    bridge;
    logic       pwm_on;
    logic [7:0] duty;
    logic [7:0] position;
    mode_t      mode_code;
    logic       fast_active;
  } result_t;

  typedef struct packed {
    mode_t       mode;
    logic [7:0]  pos;
    logic [15:0] icount;
    logic [7:0]  fduty;
    logic        latch;
    logic [7:0]  dly;
    logic [1:0]  hist;
  } gate_state_t;

  localparam gate_state_t STATE_RESET = '{
    mode:   MODE_HOMING,
    pos:    8'd0,
    icount: 16'd0,
    fduty:  DUTY_RESET,
    latch:  1'b0,
    dly:    8'd0,
    hist:   2'b00
  };

endpackage

/* rtl/gms_ifs.sv */
// Tick item channel.
interface gms_item_if;
  logic valid;
  logic ready;
  logic step_pulse;
  logic tenth_tick;
  logic half_button;
  logic full_button;
  logic confirm_button;
  logic fault;

  modport source (
    output valid, step_pulse, tenth_tick, half_button, full_button, confirm_button, fault,
    input  ready
  );
  modport sink (
    input  valid, step_pulse, tenth_tick, half_button, full_button, confirm_button, fault,
    output ready
  );
endinterface

// Drive result channel.
interface gms_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] bridge_mode;
  logic       pwm_on;
  logic [7:0] duty;
  logic [7:0] position;
  logic [2:0] mode_code;
  logic       fast_active;

  modport source (
    output valid, bridge_mode, pwm_on, duty, position, mode_code, fast_active,
    input  ready
  );
  modport sink (
    input  valid, bridge_mode, pwm_on, duty, position, mode_code, fast_active,
    output ready
  );
endinterface

/* rtl/gms_cfg_regs.sv */
module gms_cfg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [gms_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [gms_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [gms_pkg::CFG_DATA_W-1:0] prdata,
  output logic                          pready,
  output gms_pkg::cfg_t                 cfg
);
  import gms_pkg::*;

  reg_idx_t idx;

  assign idx    = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.full_open_steps     <= RST_FULL_OPEN;
      cfg.half_open_steps     <= RST_HALF_OPEN;
      cfg.fast_delay_tenths   <= RST_FAST_DELAY;
      cfg.slow_zone_steps     <= RST_SLOW_ZONE;
      cfg.expected_step_ticks <= RST_EXP_TICKS;
      cfg.fast_duty_max       <= RST_DUTY_MAX;
      cfg.fast_duty_min       <= RST_DUTY_MIN;
      cfg.slow_duty           <= RST_SLOW_DUTY;
    end else if (psel && penable && pwrite && pready) begin
      case (idx)
        REG_FULL_OPEN:  cfg.full_open_steps     <= pwdata[7:0];
        REG_HALF_OPEN:  cfg.half_open_steps     <= pwdata[7:0];
        REG_FAST_DELAY: cfg.fast_delay_tenths   <= pwdata[7:0];
        REG_SLOW_ZONE:  cfg.slow_zone_steps     <= pwdata[3:0];
        REG_EXP_TICKS:  cfg.expected_step_ticks <= pwdata[15:0];
        REG_DUTY_MAX:   cfg.fast_duty_max       <= pwdata[7:0];
        REG_DUTY_MIN:   cfg.fast_duty_min       <= pwdata[7:0];
        REG_SLOW_DUTY:  cfg.slow_duty           <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      REG_FULL_OPEN:  prdata[7:0]  = cfg.full_open_steps;
      REG_HALF_OPEN:  prdata[7:0]  = cfg.half_open_steps;
      REG_FAST_DELAY: prdata[7:0]  = cfg.fast_delay_tenths;
      REG_SLOW_ZONE:  prdata[3:0]  = cfg.slow_zone_steps;
      REG_EXP_TICKS:  prdata[15:0] = cfg.expected_step_ticks;
      REG_DUTY_MAX:   prdata[7:0]  = cfg.fast_duty_max;
      REG_DUTY_MIN:   prdata[7:0]  = cfg.fast_duty_min;
      REG_SLOW_DUTY:  prdata[7:0]  = cfg.slow_duty;
      default:        prdata       = '0;
    endcase
  end

endmodule

/* rtl/gms_divider.sv */
`include "assert_macros.svh"

// Restoring divider, one quotient bit per cycle.
module gms_divider (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [gms_pkg::DIV_NUM_W-1:0] num,
  input  logic [gms_pkg::DIV_DEN_W-1:0] den,
  output logic                         busy,
  output logic                         done,
  output logic [gms_pkg::DIV_NUM_W-1:0] quo
);
  import gms_pkg::*;

  logic [DIV_CNT_W-1:0] count;
  logic [DIV_DEN_W-1:0] den_q;
  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_DEN_W:0]   rem_sh;
  logic [DIV_DEN_W:0]   rem_sub;
  logic                 ge;

  assign busy    = (count != '0);
  assign rem_sh  = {rem, quo[DIV_NUM_W-1]};
  assign ge      = (rem_sh >= {1'b0, den_q});
  assign rem_sub = rem_sh - {1'b0, den_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        count <= DIV_CNT_W'(DIV_NUM_W);
        rem   <= '0;
        quo   <= num;
        den_q <= den;
      end else if (busy) begin
        count <= count - 1'b1;
        rem   <= ge ? rem_sub[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
        quo   <= {quo[DIV_NUM_W-2:0], ge};
        done  <= (count == DIV_CNT_W'(1));
      end
    end
  end

  `ASSERT_IMPLIES(a_start_when_free, clk, rst, start, !busy, "divider restarted while busy")
  `ASSERT_NEXT(a_done_single, clk, rst, done, !done, "divider done held longer than a cycle")
  `ASSERT_IMPLIES(a_rem_below_den, clk, rst, done && (den_q != '0), rem < den_q, "remainder not below divisor")

endmodule

/* rtl/gms_tick_logic.sv */
// Next state and drive result for one tick, given the fast duty to use.
module gms_tick_logic (
  input  gms_pkg::cfg_t        cfg,
  input  gms_pkg::gate_state_t cur,
  input  gms_pkg::item_t       itm,
  input  logic [7:0]           duty_val,
  output gms_pkg::gate_state_t nxt,
  output gms_pkg::result_t     res
);
  import gms_pkg::*;

  always_comb begin
    logic       half_edge;
    logic       full_edge;
    logic       moving;
    logic       step_mv;
    logic       acted;
    logic       evaluate;
    logic       at_delay;
    logic [7:0] target;
    logic [8:0] pos_zone;
    logic [8:0] zone_p1;

    half_edge = itm.half_button & ~cur.hist[0];
    full_edge = itm.full_button & ~cur.hist[1];
    moving    = (cur.mode == MODE_OPEN_HALF) || (cur.mode == MODE_OPEN_FULL) ||
                (cur.mode == MODE_CLOSING);
    step_mv   = itm.step_pulse & moving;
    acted     = 1'b0;
    evaluate  = 1'b0;
    at_delay  = 1'b0;
    target    = cfg.half_open_steps;
    pos_zone  = '0;
    zone_p1   = {5'd0, cfg.slow_zone_steps} + 9'd1;

    nxt        = cur;
    res.bridge = BR_BRAKE;
    res.pwm_on = 1'b0;
    res.duty   = 8'd0;

    if (itm.fault) begin
      nxt = STATE_RESET;
    end else begin
      nxt.fduty = duty_val;
      if (step_mv) begin
        nxt.icount = '0;
      end
      if (nxt.icount != IC_MAX) begin
        nxt.icount = nxt.icount + 16'd1;
      end
      if (step_mv) begin
        if (cur.mode == MODE_CLOSING) begin
          if (cur.pos != 8'd0) nxt.pos = cur.pos - 8'd1;
        end else if (cur.pos != POS_MAX) begin
          nxt.pos = cur.pos + 8'd1;
        end
      end
      if (itm.tenth_tick) begin
        nxt.dly = cur.dly + 8'd1;
      end

      case (cur.mode)
        MODE_HOMING: begin
          if (itm.confirm_button) begin
            nxt.mode = MODE_IDLE;
            nxt.pos  = 8'd0;
          end else if (itm.full_button) begin
            res.bridge = BR_CLOSE;
            res.pwm_on = 1'b1;
            res.duty   = cfg.slow_duty;
          end else if (itm.half_button) begin
            res.bridge = BR_OPEN;
            res.pwm_on = 1'b1;
            res.duty   = cfg.slow_duty;
          end
        end
        MODE_IDLE: begin
          if (half_edge) begin
            if (nxt.pos == 8'd0) begin
              nxt.mode = MODE_OPEN_HALF;
              acted    = 1'b1;
            end else if ((nxt.pos == cfg.half_open_steps) ||
                         (nxt.pos == cfg.full_open_steps)) begin
              nxt.mode = MODE_CLOSING;
              acted    = 1'b1;
            end
          end
          if (!acted && full_edge && (nxt.pos < cfg.full_open_steps)) begin
            nxt.mode = MODE_OPEN_FULL;
            acted    = 1'b1;
          end
          if (acted) begin
            nxt.dly   = 8'd0;
            nxt.latch = 1'b0;
          end
          evaluate = acted;
        end
        MODE_CLOSING: begin
          // A half press while closing brakes for this tick and reverses.
          if ((nxt.pos != 8'd0) && half_edge) begin
            nxt.mode  = (nxt.pos < cfg.half_open_steps) ? MODE_OPEN_HALF : MODE_OPEN_FULL;
            nxt.dly   = 8'd0;
            nxt.latch = 1'b0;
          end else begin
            evaluate = 1'b1;
          end
        end
        default: begin
          evaluate = 1'b1;
        end
      endcase

      if (evaluate) begin
        at_delay = (nxt.dly == cfg.fast_delay_tenths);
        if (nxt.mode == MODE_CLOSING) begin
          if (nxt.pos == 8'd0) begin
            nxt.mode  = MODE_IDLE;
            nxt.latch = 1'b0;
          end else begin
            if (at_delay && ({1'b0, nxt.pos} > zone_p1)) nxt.latch = 1'b1;
            if (nxt.pos <= {4'd0, cfg.slow_zone_steps}) nxt.latch = 1'b0;
          end
        end else begin
          target   = (nxt.mode == MODE_OPEN_FULL) ? cfg.full_open_steps : cfg.half_open_steps;
          pos_zone = {1'b0, nxt.pos} + {5'd0, cfg.slow_zone_steps};
          if (nxt.pos >= target) begin
            nxt.mode  = MODE_IDLE;
            nxt.latch = 1'b0;
          end else begin
            if (at_delay && ((pos_zone + 9'd1) < {1'b0, target})) nxt.latch = 1'b1;
            if (pos_zone >= {1'b0, target}) nxt.latch = 1'b0;
          end
        end
        if (nxt.mode != MODE_IDLE) begin
          res.bridge = (nxt.mode == MODE_CLOSING) ? BR_CLOSE : BR_OPEN;
          res.pwm_on = 1'b1;
          res.duty   = nxt.latch ? nxt.fduty : cfg.slow_duty;
        end
      end
    end

    nxt.hist        = {itm.full_button, itm.half_button};
    res.position    = nxt.pos;
    res.mode_code   = nxt.mode;
    res.fast_active = nxt.latch;
  end

endmodule

/* rtl/gate_motor_sequencer.sv */
// Channel   Dir  Handshake        Beat contents
// item      in   valid / ready    step_pulse, tenth_tick, half_button, full_button,
//                                 confirm_button, fault
// result    out  valid / ready    bridge_mode, pwm_on, duty, position, mode_code,
//                                 fast_active
// config    in   APB, pready = 1  eight registers at byte addresses 0 to 28
//
// An item passes the idle and apply steps, and also both multiply steps, the divide
// and the scale step when a step pulse arrives during a move at fast speed and the
// step interval lies within the mapped window. The divide is one pass through the
// 24-bit divider, one quotient bit a cycle; the span is divided via its reciprocal.
// Reset is synchronous and active high; it returns the gate to homing and the
// registers to their defaults, with no clearing pass.
// A new item is taken while an earlier result still waits; the block stalls only
// in its final step until the result register has room.
`include "assert_macros.svh"

module gate_motor_sequencer (
  input  logic                          clk,
  input  logic                          rst,
  gms_item_if.sink                      item,
  gms_result_if.source                  result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [gms_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [gms_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [gms_pkg::CFG_DATA_W-1:0] prdata,
  output logic                          pready
);
  import gms_pkg::*;

  // Sequencer steps. A fast duty update needs d*10000/E, a multiply followed by
  // a divide, and then (50000 - that)*max/50000, where the division by the fixed
  // span is a shift and a multiply by a reciprocal.
  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL1,
    S_DIV1,
    S_MUL2,
    S_SCALE,
    S_APPLY
  } fsm_t;

  fsm_t                  fsm;
  cfg_t                  cfg;
  gate_state_t           st;
  gate_state_t           st_next;
  item_t                 item_q;
  result_t               res_next;
  result_t               out_q;
  logic                  out_valid;
  logic                  use_calc;
  logic [7:0]            calc_duty;
  logic [7:0]            duty_val;
  logic [8:0]            d_q;
  logic [15:0]           vp_q;
  logic [DIV_NUM_W-1:0]  prod;
  logic [MUL_W-1:0]      mul_a;
  logic [MUL_W-1:0]      mul_b;
  logic [2*MUL_W-1:0]    mul_p;
  logic                  div_start;
  logic                  div_busy;
  logic                  div_done;
  logic [DIV_NUM_W-1:0]  div_quo;
  logic                  moving;
  logic                  need_calc;
  logic [15:0]           diff;

  gms_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  gms_divider u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (prod),
    .den   (cfg.expected_step_ticks),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_quo)
  );

  // One multiplier, shared by the two multiply steps and the span scaling.
  always_comb begin
    case (fsm)
      S_MUL1: begin
        mul_a = MUL_W'(d_q);
        mul_b = MUL_W'(DUTY_SCALE);
      end
      S_SCALE: begin
        mul_a = MUL_W'(prod[DIV_NUM_W-1:SPAN_SHIFT]);
        mul_b = RECIP_SPAN;
      end
      default: begin
        mul_a = MUL_W'(vp_q);
        mul_b = MUL_W'(cfg.fast_duty_max);
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // Fast duty is recomputed only on a step pulse while moving at fast speed.
  assign moving    = (st.mode == MODE_OPEN_HALF) || (st.mode == MODE_OPEN_FULL) ||
                     (st.mode == MODE_CLOSING);
  assign need_calc = !item.fault && item.step_pulse && moving && st.latch;
  assign diff      = cfg.expected_step_ticks - st.icount;

  assign duty_val = use_calc ? calc_duty : st.fduty;

  gms_tick_logic u_tick (
    .cfg      (cfg),
    .cur      (st),
    .itm      (item_q),
    .duty_val (duty_val),
    .nxt      (st_next),
    .res      (res_next)
  );

  assign item.ready         = (fsm == S_IDLE);
  assign result.valid       = out_valid;
  assign result.bridge_mode = out_q.bridge;
  assign result.pwm_on      = out_q.pwm_on;
  assign result.duty        = out_q.duty;
  assign result.position    = out_q.position;
  assign result.mode_code   = out_q.mode_code;
  assign result.fast_active = out_q.fast_active;

  always_ff @(posedge clk) begin
    if (rst) begin
      fsm       <= S_IDLE;
      st        <= STATE_RESET;
      out_valid <= 1'b0;
      div_start <= 1'b0;
      use_calc  <= 1'b0;
    end else begin
      div_start <= 1'b0;
      if (out_valid && result.ready) begin
        out_valid <= 1'b0;
      end
      case (fsm)
        S_IDLE: begin
          if (item.valid) begin
            item_q.step_pulse     <= item.step_pulse;
            item_q.tenth_tick     <= item.tenth_tick;
            item_q.half_button    <= item.half_button;
            item_q.full_button    <= item.full_button;
            item_q.confirm_button <= item.confirm_button;
            item_q.fault          <= item.fault;
            use_calc              <= need_calc;
            fsm                   <= S_APPLY;
            if (need_calc) begin
              // Steps slower than expected, far too fast, or no expected
              // interval at all map straight to a limit.
              if (st.icount > cfg.expected_step_ticks) begin
                calc_duty <= cfg.fast_duty_max;
              end else if (diff > SLOW_LIMIT) begin
                calc_duty <= cfg.fast_duty_min;
              end else if (cfg.expected_step_ticks == '0) begin
                calc_duty <= cfg.fast_duty_max;
              end else begin
                d_q <= diff[8:0];
                fsm <= S_MUL1;
              end
            end
          end
        end
        S_MUL1: begin
          prod      <= mul_p[DIV_NUM_W-1:0];
          div_start <= 1'b1;
          fsm       <= S_DIV1;
        end
        S_DIV1: begin
          if (div_done) begin
            if (div_quo > {8'd0, DUTY_SPAN}) begin
              vp_q <= '0;
            end else begin
              vp_q <= DUTY_SPAN - div_quo[15:0];
            end
            fsm <= S_MUL2;
          end
        end
        S_MUL2: begin
          prod <= mul_p[DIV_NUM_W-1:0];
          fsm  <= S_SCALE;
        end
        S_SCALE: begin
          calc_duty <= mul_p[RECIP_SHIFT+7:RECIP_SHIFT];
          fsm       <= S_APPLY;
        end
        S_APPLY: begin
          // Commit the tick once the result register has room.
          if (!out_valid || result.ready) begin
            st        <= st_next;
            out_q     <= res_next;
            out_valid <= 1'b1;
            fsm       <= S_IDLE;
          end
        end
        default: begin
          fsm <= S_IDLE;
        end
      endcase
    end
  end

  `ASSERT_IMPLIES(a_done_in_div, clk, rst, div_done, fsm == S_DIV1, "divider finished outside the divide step")
  `ASSERT_IMPLIES(a_busy_in_div, clk, rst, div_busy, fsm == S_DIV1, "divider running outside the divide step")
  `ASSERT_IMPLIES(a_duty_bound, clk, rst, fsm == S_SCALE, mul_p[2*MUL_W-1:RECIP_SHIFT] <= {2'd0, cfg.fast_duty_max}, "mapped duty above the fast maximum")
  `ASSERT_IMPLIES(a_idle_pwm, clk, rst, out_valid && !out_q.pwm_on, out_q.duty == 8'd0, "duty shown with PWM off")
  `ASSERT_IMPLIES(a_fast_moving, clk, rst, out_valid && out_q.fast_active, (out_q.mode_code == MODE_OPEN_HALF) || (out_q.mode_code == MODE_OPEN_FULL) || (out_q.mode_code == MODE_CLOSING), "fast speed outside a move")

endmodule
